[hdl/window_local_max_detector_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the window local maximum detector.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef WINDOW_LOCAL_MAX_DETECTOR_UNIT_MACROS_SVH
`define WINDOW_LOCAL_MAX_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define WLMD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only.
`define WLMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wlmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlmd_pkg
// Shared types, field widths, codes and reset values of the window local
// maximum detector.
// ----------------------------------------------------------------------------
package wlmd_pkg;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 7;
  localparam int RESP_W  = 32;
  localparam int RAD_W   = 4;
  localparam int FSIZE_W = 8;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [RESP_W-1:0]  THRESH_RESET = 32'd214748;
  localparam logic [RAD_W-1:0]   RADIUS_RESET = 4'd4;
  localparam logic [FSIZE_W-1:0] WIDTH_RESET  = 8'd128;
  localparam logic [FSIZE_W-1:0] HEIGHT_RESET = 8'd128;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RADIUS    = 2'd1,
    REG_WIDTH     = 2'd2,
    REG_HEIGHT    = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } wlmd_state_e;

  // Signed greater-than on two's complement response words.
  function automatic logic sgt(logic [RESP_W-1:0] a, logic [RESP_W-1:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

[hdl/wlmd_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlmd item and result channels
// Valid/ready channels carrying one input item and one result item.
// ----------------------------------------------------------------------------
interface wlmd_item_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [wlmd_pkg::COL_W-1:0]     col;
  logic [wlmd_pkg::ROW_W-1:0]     row;
  logic [wlmd_pkg::RESP_W-1:0]    response;

  modport source (output valid, func, col, row, response, input ready);
  modport sink   (input valid, func, col, row, response, output ready);
endinterface

interface wlmd_result_if;
  logic valid;
  logic ready;
  logic is_corner;
  logic out_of_frame;

  modport source (output valid, is_corner, out_of_frame, input ready);
  modport sink   (input valid, is_corner, out_of_frame, output ready);
endinterface

[hdl/wlmd_frame_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlmd_frame_store
// Response sample memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wlmd_frame_store #(
  parameter int DEPTH = 16384
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [$clog2(DEPTH)-1:0]            waddr_i,
  input  logic [wlmd_pkg::RESP_W-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0]            raddr_i,
  output logic [wlmd_pkg::RESP_W-1:0]         rdata_o
);

  logic [wlmd_pkg::RESP_W-1:0] mem [DEPTH];
  logic [wlmd_pkg::RESP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/window_local_max_detector_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_local_max_detector_unit
// Stores a signed Q1.30 corner-response surface and answers whether a stored
// sample is a thresholded strict maximum of its clamped square window.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  item_i    in         valid/ready          func, col, row, response
//  result_o  out        valid/ready          is_corner, out_of_frame
//  APB       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// A write transaction, and any transaction outside the frame, goes from
// acceptance straight to ST_DONE and back to ST_IDLE.
// A query steps through ST_CENTRE, ST_SCAN and ST_DRAIN to ST_DONE; every
// window sample is fetched through the single read port of the frame store,
// one per cycle. A query ends early when the centre fails the threshold or a
// neighbor is not strictly below it.
// Reset is asynchronous and active low; the frame store is not cleared.
// The result sits in an output register, so a stalled result only holds the
// sequencer in its final state while the next item waits.
// ----------------------------------------------------------------------------
module window_local_max_detector_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_RADIUS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wlmd_item_if.sink                       item_i,
  wlmd_result_if.source                   result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wlmd_pkg::PADDR_W-1:0]    paddr,
  input  logic [wlmd_pkg::PDATA_W-1:0]    pwdata,
  output logic [wlmd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  // Coordinate width: holds an input coordinate, a frame size register and
  // the largest frame dimension.
  localparam int CWA = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                       $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  localparam int CW  = (CWA > wlmd_pkg::FSIZE_W) ? CWA : wlmd_pkg::FSIZE_W;
  // Signed width for a coordinate plus a window offset.
  localparam int SW  = CW + 2;
  // Radius widths: unsigned saturated radius, and signed offset counter.
  localparam int RUW = $clog2(MAX_RADIUS + 1);
  localparam int RW  = RUW + 1;
  localparam int RCW = (RUW > wlmd_pkg::RAD_W) ? RUW : wlmd_pkg::RAD_W;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

  // --------------------------------------------------------------------------
  // Configuration registers. pready is tied high, so every access completes
  // in its access phase.
  // --------------------------------------------------------------------------
  logic [wlmd_pkg::RESP_W-1:0]  thresh_q;
  logic [wlmd_pkg::RAD_W-1:0]   radius_q;
  logic [wlmd_pkg::FSIZE_W-1:0] fwidth_q;
  logic [wlmd_pkg::FSIZE_W-1:0] fheight_q;
  wlmd_pkg::cfg_reg_e           reg_sel;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = wlmd_pkg::cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= wlmd_pkg::THRESH_RESET;
      radius_q  <= wlmd_pkg::RADIUS_RESET;
      fwidth_q  <= wlmd_pkg::WIDTH_RESET;
      fheight_q <= wlmd_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        wlmd_pkg::REG_THRESHOLD: thresh_q  <= pwdata;
        wlmd_pkg::REG_RADIUS:    radius_q  <= pwdata[wlmd_pkg::RAD_W-1:0];
        wlmd_pkg::REG_WIDTH:     fwidth_q  <= pwdata[wlmd_pkg::FSIZE_W-1:0];
        wlmd_pkg::REG_HEIGHT:    fheight_q <= pwdata[wlmd_pkg::FSIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      wlmd_pkg::REG_THRESHOLD: prdata = thresh_q;
      wlmd_pkg::REG_RADIUS:    prdata = wlmd_pkg::PDATA_W'(radius_q);
      wlmd_pkg::REG_WIDTH:     prdata = wlmd_pkg::PDATA_W'(fwidth_q);
      wlmd_pkg::REG_HEIGHT:    prdata = wlmd_pkg::PDATA_W'(fheight_q);
    endcase
  end

  // --------------------------------------------------------------------------
  // Effective frame size and radius. Register values beyond what the store
  // holds saturate to the synthesized maximum.
  // --------------------------------------------------------------------------
  logic [CW-1:0]        fw, fh, fw_m1, fh_m1;
  logic [RCW-1:0]       rad_wide;
  logic [RUW-1:0]       rad;
  logic signed [RW-1:0] rad_s;

  assign fw = (CW'(fwidth_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fwidth_q);
  assign fh = (CW'(fheight_q) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(fheight_q);
  assign fw_m1 = fw - CW'(1);
  assign fh_m1 = fh - CW'(1);
  assign rad_wide = (RCW'(radius_q) > RCW'(MAX_RADIUS)) ? RCW'(MAX_RADIUS)
                                                        : RCW'(radius_q);
  assign rad   = RUW'(rad_wide);
  assign rad_s = $signed({1'b0, rad});

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  wlmd_pkg::wlmd_state_e        state_q, state_d;
  logic [wlmd_pkg::COL_W-1:0]   col_q, col_d;
  logic [wlmd_pkg::ROW_W-1:0]   row_q, row_d;
  logic [wlmd_pkg::RESP_W-1:0]  centre_q, centre_d;
  logic signed [RW-1:0]         dx_q, dx_d, dy_q, dy_d;
  logic                         pend_q, pend_d;
  logic                         corner_q, corner_d;
  logic                         oof_q, oof_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_corner_q, out_corner_d;
  logic                         out_oof_q, out_oof_d;

  // Item side
  logic          item_acc;
  logic          oof_in;
  logic [AW-1:0] addr_in;

  assign item_i.ready = (state_q == wlmd_pkg::ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;
  assign oof_in       = (CW'(item_i.col) >= fw) || (CW'(item_i.row) >= fh);
  assign addr_in      = AW'(item_i.row) * ROW_STRIDE + AW'(item_i.col);

  // Window position: offset from the centre, clamped to the frame.
  logic signed [SW-1:0] x_s, y_s;
  logic [CW-1:0]        x2, y2;
  logic                 is_centre;
  logic [AW-1:0]        scan_addr;

  assign x_s = $signed(SW'(col_q)) + SW'(dx_q);
  assign y_s = $signed(SW'(row_q)) + SW'(dy_q);

  always_comb begin
    if (x_s < 0) begin
      x2 = '0;
    end else if (x_s > $signed(SW'(fw_m1))) begin
      x2 = fw_m1;
    end else begin
      x2 = CW'(x_s);
    end
    if (y_s < 0) begin
      y2 = '0;
    end else if (y_s > $signed(SW'(fh_m1))) begin
      y2 = fh_m1;
    end else begin
      y2 = CW'(y_s);
    end
  end

  // A clamped position that lands on the centre is skipped like the centre.
  assign is_centre = (x2 == CW'(col_q)) && (y2 == CW'(row_q));
  assign scan_addr = AW'(y2) * ROW_STRIDE + AW'(x2);

  // Frame store: writes land on acceptance; reads are issued from the item
  // for the centre and from the window position during the scan.
  logic                        mem_we;
  logic [AW-1:0]               mem_raddr;
  logic [wlmd_pkg::RESP_W-1:0] mem_rdata;

  assign mem_we    = item_acc && (item_i.func == wlmd_pkg::FUNC_WRITE) && !oof_in;
  assign mem_raddr = (state_q == wlmd_pkg::ST_IDLE) ? addr_in : scan_addr;

  wlmd_frame_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_in),
    .wdata_i (item_i.response),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared comparator. The threshold check tests threshold > centre, every
  // window check tests centre > neighbor; the right operand is always the
  // sample just read from the store.
  logic [wlmd_pkg::RESP_W-1:0] cmp_a;
  logic                        cmp_gt;

  assign cmp_a  = (state_q == wlmd_pkg::ST_CENTRE) ? thresh_q : centre_q;
  assign cmp_gt = wlmd_pkg::sgt(cmp_a, mem_rdata);

  logic out_free;
  logic scan_last;

  assign out_free  = !out_valid_q || result_o.ready;
  assign scan_last = (dx_q == rad_s) && (dy_q == rad_s);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    centre_d     = centre_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    pend_d       = pend_q;
    corner_d     = corner_q;
    oof_d        = oof_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_corner_d = out_corner_q;
    out_oof_d    = out_oof_q;

    unique case (state_q)
      wlmd_pkg::ST_IDLE: begin
        if (item_acc) begin
          col_d    = item_i.col;
          row_d    = item_i.row;
          oof_d    = oof_in;
          corner_d = 1'b0;
          if ((item_i.func == wlmd_pkg::FUNC_QUERY) && !oof_in) begin
            state_d = wlmd_pkg::ST_CENTRE;
          end else begin
            state_d = wlmd_pkg::ST_DONE;
          end
        end
      end

      wlmd_pkg::ST_CENTRE: begin
        centre_d = mem_rdata;
        if (cmp_gt) begin
          state_d = wlmd_pkg::ST_DONE;
        end else begin
          corner_d = 1'b1;
          dx_d     = -rad_s;
          dy_d     = -rad_s;
          pend_d   = 1'b0;
          state_d  = wlmd_pkg::ST_SCAN;
        end
      end

      wlmd_pkg::ST_SCAN: begin
        // Check the sample read last cycle while issuing the next read.
        if (pend_q && !cmp_gt) begin
          corner_d = 1'b0;
          pend_d   = 1'b0;
          state_d  = wlmd_pkg::ST_DONE;
        end else begin
          pend_d = !is_centre;
          if (scan_last) begin
            state_d = wlmd_pkg::ST_DRAIN;
          end else if (dx_q == rad_s) begin
            dx_d = -rad_s;
            dy_d = dy_q + $signed(RW'(1));
          end else begin
            dx_d = dx_q + $signed(RW'(1));
          end
        end
      end

      wlmd_pkg::ST_DRAIN: begin
        if (pend_q && !cmp_gt) begin
          corner_d = 1'b0;
        end
        pend_d  = 1'b0;
        state_d = wlmd_pkg::ST_DONE;
      end

      wlmd_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_corner_d = corner_q;
          out_oof_d    = oof_q;
          state_d      = wlmd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = wlmd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wlmd_pkg::ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    row_q        <= row_d;
    centre_q     <= centre_d;
    dx_q         <= dx_d;
    dy_q         <= dy_d;
    corner_q     <= corner_d;
    oof_q        <= oof_d;
    out_corner_q <= out_corner_d;
    out_oof_q    <= out_oof_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.is_corner    = out_corner_q;
  assign result_o.out_of_frame = out_oof_q;

endmodule

[hdl/wlmd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlmd_checker
// Port-level checks of the window local maximum detector, bound to the top.
// ----------------------------------------------------------------------------
`include "window_local_max_detector_unit_macros.svh"

module wlmd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic item_valid_i,
  input logic item_ready_i,
  input logic result_valid_i,
  input logic result_ready_i,
  input logic is_corner_i,
  input logic out_of_frame_i
);

  // The block works on one transaction at a time.
  `WLMD_ASSERT_NEXT(a_busy_after_accept, item_valid_i && item_ready_i, !item_ready_i, "item accepted while the previous one was still in work")

  // A corner can only be reported for a position inside the frame.
  `WLMD_ASSERT_NOW(a_corner_in_frame, result_valid_i && is_corner_i, !out_of_frame_i, "corner reported for a position outside the frame")

  // A stalled result holds its payload.
  `WLMD_ASSERT_NEXT(a_result_hold, result_valid_i && !result_ready_i, result_valid_i && $stable(is_corner_i) && $stable(out_of_frame_i), "stalled result changed or dropped")

endmodule

bind window_local_max_detector_unit wlmd_checker u_wlmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .item_valid_i   (item_i.valid),
  .item_ready_i   (item_i.ready),
  .result_valid_i (result_o.valid),
  .result_ready_i (result_o.ready),
  .is_corner_i    (result_o.is_corner),
  .out_of_frame_i (result_o.out_of_frame)
);
